// File: src/sparse_polynomial_adder_defines.svh
// Assertion macros used by the RTL of the sparse polynomial adder.
`ifndef SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SPA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sparse polynomial adder: assertion failed");
// Next-cycle implication.
`define SPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sparse polynomial adder: assertion failed");
`else
`define SPA_ASSERT_NOW(label, ante, cons)
`define SPA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/spa_pkg.sv
package spa_pkg;

	localparam int COEFF_W = 32;
	localparam int EXP_W   = 8;

	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic [EXP_W-1:0]          exp_t;

	typedef struct packed {
		coeff_t coeff;
		exp_t   exp;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPEND,
		ST_MRG_RD,
		ST_MRG_CMP,
		ST_FINISH,
		ST_SORT_I,
		ST_SORT_IL,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_WB,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_WAIT
	} state_t;

endpackage

// File: src/spa_term_if.sv
interface spa_term_if;
	logic            valid;
	logic            ready;
	logic            req_type;
	spa_pkg::coeff_t term_coeff;
	spa_pkg::exp_t   term_exp;
	logic            end_of_sum;

	modport source (output valid, output req_type, output term_coeff, output term_exp,
		output end_of_sum, input ready);
	modport sink (input valid, input req_type, input term_coeff, input term_exp,
		input end_of_sum, output ready);
endinterface

// File: src/spa_sum_if.sv
interface spa_sum_if;
	logic            valid;
	logic            ready;
	spa_pkg::coeff_t sum_coeff;
	spa_pkg::exp_t   sum_exp;
	logic            run_last;
	logic            overflow;

	modport source (output valid, output sum_coeff, output sum_exp, output run_last,
		output overflow, input ready);
	modport sink (input valid, input sum_coeff, input sum_exp, input run_last,
		input overflow, output ready);
endinterface

// File: src/sparse_polynomial_adder.sv
// Sparse polynomial adder. Terms of the first polynomial (req_type 0) and then of the second
// (req_type 1) arrive one transaction at a time and are collected in a table of MAX_TERMS
// entries held in a single memory with one registered read port and one write port. A term is
// taken only while the block is idle. A first-operand term is appended in state APPEND and
// the block is ready again after FINISH. A second-operand term is compared against the first
// operand's entries one entry at a time (MRG_RD, then MRG_CMP) through the single exponent
// comparator. On the term marked end_of_sum the table is exchange-sorted with descending
// exponents through the same memory port and is then emitted one result at a time, each held
// until the sink takes it, the final result marked run_last. Terms that find no room are
// dropped and overflow is set on every result of that run. The table is empty again once the
// last result is taken.
module sparse_polynomial_adder #(
	parameter int MAX_TERMS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	spa_term_if.sink   term,
	spa_sum_if.source  sum
);

	`include "sparse_polynomial_adder_defines.svh"

	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TERMS);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);
	localparam logic [CW-1:0] TWO_CNT = CW'(2);
	localparam logic [AW-1:0] ONE_IDX = AW'(1);

	spa_pkg::state_t state_q, state_n;

	logic [CW-1:0] entry_cnt_q, entry_cnt_n;
	logic [CW-1:0] first_cnt_q, first_cnt_n;
	logic          dropped_q, dropped_n;
	logic [AW-1:0] k_q, k_n;
	logic [AW-1:0] i_q, i_n;
	logic [AW-1:0] j_q, j_n;
	logic          hit_q, hit_n;
	spa_pkg::entry_t cur_q, cur_n;

	logic            req_type_q;
	spa_pkg::coeff_t coeff_q;
	spa_pkg::exp_t   exp_q;
	logic            last_q;

	spa_pkg::entry_t mem [MAX_TERMS];
	spa_pkg::entry_t rd_q;
	logic            we;
	logic [AW-1:0]   wr_addr;
	spa_pkg::entry_t wr_data;
	logic [AW-1:0]   rd_addr;

	logic            load_out;
	spa_pkg::coeff_t sum_coeff_q;
	spa_pkg::exp_t   sum_exp_q;
	logic            run_last_q;
	logic            overflow_q;

	logic term_acc;

	assign term.ready = (state_q == spa_pkg::ST_IDLE);
	assign term_acc   = term.valid && term.ready;

	assign sum.valid     = (state_q == spa_pkg::ST_EMIT_WAIT);
	assign sum.sum_coeff = sum_coeff_q;
	assign sum.sum_exp   = sum_exp_q;
	assign sum.run_last  = run_last_q;
	assign sum.overflow  = overflow_q;

	always_comb begin
		state_n     = state_q;
		entry_cnt_n = entry_cnt_q;
		first_cnt_n = first_cnt_q;
		dropped_n   = dropped_q;
		k_n         = k_q;
		i_n         = i_q;
		j_n         = j_q;
		hit_n       = hit_q;
		cur_n       = cur_q;
		we          = 1'b0;
		wr_addr     = k_q;
		wr_data     = cur_q;
		rd_addr     = k_q;
		load_out    = 1'b0;
		case (state_q)
			spa_pkg::ST_IDLE: begin
				if (term.valid) begin
					if (!term.req_type || (first_cnt_q == '0)) begin
						state_n = spa_pkg::ST_APPEND;
					end else begin
						k_n     = '0;
						hit_n   = 1'b0;
						state_n = spa_pkg::ST_MRG_RD;
					end
				end
			end
			spa_pkg::ST_APPEND: begin
				if (entry_cnt_q < MAX_CNT) begin
					we          = 1'b1;
					wr_addr     = entry_cnt_q[AW-1:0];
					wr_data     = '{coeff: coeff_q, exp: exp_q};
					entry_cnt_n = entry_cnt_q + ONE_CNT;
				end else begin
					dropped_n = 1'b1;
				end
				// A first-operand term makes every entry so far matchable.
				if (!req_type_q) begin
					first_cnt_n = entry_cnt_n;
				end
				state_n = spa_pkg::ST_FINISH;
			end
			spa_pkg::ST_MRG_RD: begin
				rd_addr = k_q;
				state_n = spa_pkg::ST_MRG_CMP;
			end
			spa_pkg::ST_MRG_CMP: begin
				if (rd_q.exp == exp_q) begin
					we      = 1'b1;
					wr_addr = k_q;
					wr_data = '{coeff: rd_q.coeff + coeff_q, exp: rd_q.exp};
					hit_n   = 1'b1;
				end
				if ((CW'(k_q) + ONE_CNT) < first_cnt_q) begin
					k_n     = k_q + ONE_IDX;
					state_n = spa_pkg::ST_MRG_RD;
				end else if (hit_n) begin
					state_n = spa_pkg::ST_FINISH;
				end else begin
					state_n = spa_pkg::ST_APPEND;
				end
			end
			spa_pkg::ST_FINISH: begin
				if (!last_q) begin
					state_n = spa_pkg::ST_IDLE;
				end else if (entry_cnt_q == '0) begin
					entry_cnt_n = '0;
					first_cnt_n = '0;
					dropped_n   = 1'b0;
					state_n     = spa_pkg::ST_IDLE;
				end else if (entry_cnt_q == ONE_CNT) begin
					k_n     = '0;
					state_n = spa_pkg::ST_EMIT_RD;
				end else begin
					i_n     = '0;
					state_n = spa_pkg::ST_SORT_I;
				end
			end
			spa_pkg::ST_SORT_I: begin
				rd_addr = i_q;
				state_n = spa_pkg::ST_SORT_IL;
			end
			spa_pkg::ST_SORT_IL: begin
				cur_n   = rd_q;
				j_n     = i_q + ONE_IDX;
				state_n = spa_pkg::ST_SORT_RD;
			end
			spa_pkg::ST_SORT_RD: begin
				rd_addr = j_q;
				state_n = spa_pkg::ST_SORT_CMP;
			end
			spa_pkg::ST_SORT_CMP: begin
				// Entry i lives in cur_q during the inner pass; a swap writes it to slot j.
				if (cur_q.exp < rd_q.exp) begin
					we      = 1'b1;
					wr_addr = j_q;
					wr_data = cur_q;
					cur_n   = rd_q;
				end
				if ((CW'(j_q) + ONE_CNT) < entry_cnt_q) begin
					j_n     = j_q + ONE_IDX;
					state_n = spa_pkg::ST_SORT_RD;
				end else begin
					state_n = spa_pkg::ST_SORT_WB;
				end
			end
			spa_pkg::ST_SORT_WB: begin
				we      = 1'b1;
				wr_addr = i_q;
				wr_data = cur_q;
				if ((CW'(i_q) + TWO_CNT) < entry_cnt_q) begin
					i_n     = i_q + ONE_IDX;
					state_n = spa_pkg::ST_SORT_I;
				end else begin
					k_n     = '0;
					state_n = spa_pkg::ST_EMIT_RD;
				end
			end
			spa_pkg::ST_EMIT_RD: begin
				rd_addr = k_q;
				state_n = spa_pkg::ST_EMIT_LD;
			end
			spa_pkg::ST_EMIT_LD: begin
				load_out = 1'b1;
				state_n  = spa_pkg::ST_EMIT_WAIT;
			end
			spa_pkg::ST_EMIT_WAIT: begin
				if (sum.ready) begin
					if ((CW'(k_q) + ONE_CNT) == entry_cnt_q) begin
						entry_cnt_n = '0;
						first_cnt_n = '0;
						dropped_n   = 1'b0;
						state_n     = spa_pkg::ST_IDLE;
					end else begin
						k_n     = k_q + ONE_IDX;
						state_n = spa_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_n = spa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spa_pkg::ST_IDLE;
			entry_cnt_q <= '0;
			first_cnt_q <= '0;
			dropped_q   <= 1'b0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			hit_q       <= 1'b0;
		end else begin
			state_q     <= state_n;
			entry_cnt_q <= entry_cnt_n;
			first_cnt_q <= first_cnt_n;
			dropped_q   <= dropped_n;
			k_q         <= k_n;
			i_q         <= i_n;
			j_q         <= j_n;
			hit_q       <= hit_n;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_n;
		if (term_acc) begin
			req_type_q <= term.req_type;
			coeff_q    <= term.term_coeff;
			exp_q      <= term.term_exp;
			last_q     <= term.end_of_sum;
		end
		if (load_out) begin
			sum_coeff_q <= rd_q.coeff;
			sum_exp_q   <= rd_q.exp;
			run_last_q  <= ((CW'(k_q) + ONE_CNT) == entry_cnt_q);
			overflow_q  <= dropped_q;
		end
	end

	// Term table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	`SPA_ASSERT_NOW(a_cnt_bound, 1'b1, (entry_cnt_q <= MAX_CNT) && (first_cnt_q <= entry_cnt_q))
	`SPA_ASSERT_NOW(a_drop_when_full, $rose(dropped_q), entry_cnt_q == MAX_CNT)
	`SPA_ASSERT_NEXT(a_run_clears, sum.valid && sum.ready && sum.run_last, (entry_cnt_q == '0) && !dropped_q && term.ready)
	`SPA_ASSERT_NOW(a_emit_in_range, sum.valid, CW'(k_q) < entry_cnt_q)

endmodule
